FILE: src/cylinder_mesh_vertex_generator_unit_macros.svh
// Assertion macros for the cylinder mesh vertex generator top level.
`ifndef CYLINDER_MESH_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define CYLINDER_MESH_VERTEX_GENERATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CMVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CMVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: src/cmvg_pkg.sv
// Package with constants, types and the arctangent table of the cylinder mesh generator.
`timescale 1ns / 1ps
package cmvg_pkg;
	localparam int MaxSegmentsDef = 1024;
	localparam int CordicStagesDef = 16;
	localparam int TableLen = 24;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	localparam logic [1:0] OP_SIDE = 2'd0;
	localparam logic [1:0] OP_TOP = 2'd1;
	localparam logic [1:0] OP_BOTTOM = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} rot_t;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] r;
		begin
			case (i)
				0: r = 34'sd536870912;
				1: r = 34'sd316933406;
				2: r = 34'sd167458907;
				3: r = 34'sd85004756;
				4: r = 34'sd42667331;
				5: r = 34'sd21354465;
				6: r = 34'sd10679838;
				7: r = 34'sd5340245;
				8: r = 34'sd2670163;
				9: r = 34'sd1335087;
				10: r = 34'sd667544;
				11: r = 34'sd333772;
				12: r = 34'sd166886;
				13: r = 34'sd83443;
				14: r = 34'sd41722;
				15: r = 34'sd20861;
				16: r = 34'sd10430;
				17: r = 34'sd5215;
				18: r = 34'sd2608;
				19: r = 34'sd1304;
				20: r = 34'sd652;
				21: r = 34'sd326;
				22: r = 34'sd163;
				23: r = 34'sd81;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage

FILE: src/cmvg_cell.sv
// One CORDIC rotation cell that passes its rotated vector to the next cell each cycle.
`timescale 1ns / 1ps
module cmvg_cell #(
	parameter int Stage = 0
) (
	input logic clk,
	input cmvg_pkg::rot_t din,
	output cmvg_pkg::rot_t dout_q
);
	import cmvg_pkg::*;
	rot_t nxt;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	always_comb begin
		dx = din.y >>> Stage;
		dy = din.x >>> Stage;
		if (!din.z[33]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - atan_turn(Stage);
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + atan_turn(Stage);
		end
	end
	always_ff @(posedge clk) begin
		dout_q <= nxt;
	end
endmodule

FILE: src/cmvg_angle.sv
// Phase divider: works out floor(k * 2^24 / n) one quotient bit per cell cycle.
`timescale 1ns / 1ps
module cmvg_angle #(
	parameter int Bits = 24
) (
	input logic clk,
	input logic [10:0] num,
	input logic [10:0] den,
	output logic [Bits-1:0] quo
);
	import cmvg_pkg::*;
	logic [11:0] rem_q [Bits+1];
	logic [Bits-1:0] q_q [Bits+1];
	logic [10:0] den_q [Bits+1];
	always_comb begin
		rem_q[0] = {1'b0, num};
		q_q[0] = '0;
		den_q[0] = den;
	end
	for (genvar i = 0; i < Bits; i++) begin : g_div
		logic [12:0] t;
		logic ge;
		always_comb begin
			t = {rem_q[i], 1'b0};
			ge = t >= {2'b00, den_q[i]};
		end
		always_ff @(posedge clk) begin
			rem_q[i+1] <= ge ? 12'(t - {2'b00, den_q[i]}) : t[11:0];
			q_q[i+1] <= {q_q[i][Bits-2:0], ge};
			den_q[i+1] <= den_q[i];
		end
	end
	assign quo = q_q[Bits];
endmodule

FILE: src/cylinder_mesh_vertex_generator_unit.sv
// Top level of the cylinder mesh vertex generator.
`timescale 1ns / 1ps
`include "cylinder_mesh_vertex_generator_unit_macros.svh"
// Usage:
// A command transfer happens at a clock edge with start high and busy low; it carries
// opcode (0 side, 1 top cap, 2 bottom cap, 3 ignored) and segment_index.
// Configuration registers radius, height and segment_count are written over the
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data); the user must do so only
// while the block is idle, which the block does not enforce. Each command passes
// through a 24-cell phase divider and a chain of CORDIC cells, then the product,
// rounding and capture registers before its first result shows. Both angle endpoints
// of a segment pass the same chain back to back. Results come out one vertex per
// cycle, each marked by out_valid for one cycle, last on the final vertex.
// A side wall gives six results, a cap three, a bad index one.
// busy holds off start after every transfer (cap and bad commands included), spacing
// commands to match the six side-wall results; earlier commands may still be in flight.
// Reset clears the registers to their defaults and empties the pipeline.
// The receiver cannot stall; every result is taken in the cycle it is shown.
module cylinder_mesh_vertex_generator_unit #(
	parameter int MAX_SEGMENTS = cmvg_pkg::MaxSegmentsDef,
	parameter int CORDIC_STAGES = cmvg_pkg::CordicStagesDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [9:0] segment_index,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic out_valid,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic last,
	output logic bad_index
);
	import cmvg_pkg::*;
	localparam int NSt = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
	localparam int DivBits = 24;
	localparam int Lat = DivBits + NSt + 3;

	logic [14:0] radius_q;
	logic [15:0] height_q;
	logic [10:0] count_q;
	logic [2:0] busy_q;
	logic [10:0] n_eff;
	logic take;

	assign cfg_ready = 1'b1;
	assign n_eff = (13'(count_q) > 13'(MAX_SEGMENTS)) ? 11'(MAX_SEGMENTS) : count_q;
	assign busy = busy_q != 3'd0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 15'd256;
			height_q <= 16'd512;
			count_q <= 11'd32;
			busy_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data[14:0];
					REG_HEIGHT: height_q <= cfg_data;
					REG_COUNT: count_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (take) busy_q <= 3'd5;
			else if (busy_q != 3'd0) busy_q <= busy_q - 3'd1;
		end
	end

	// Sequence two angle entries per command: k then k + 1.
	logic second_q;
	logic [10:0] k1_q;
	logic [10:0] div_num;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) second_q <= 1'b0;
		else second_q <= take;
	end
	always_ff @(posedge clk) begin
		if (take) k1_q <= 11'(segment_index) + 11'd1;
	end
	// The divider wants num < den; k + 1 = n is the full turn, which is angle 0.
	// Larger numerators only occur for bad indices whose result is discarded.
	assign div_num = second_q ? ((k1_q < n_eff) ? k1_q : 11'd0) : 11'(segment_index);

	logic [DivBits-1:0] phase;
	cmvg_angle #(.Bits(DivBits)) u_angle (
		.clk(clk), .num(div_num), .den(n_eff), .quo(phase)
	);

	// Side texture u is floor(k * 2^16 / n) rounded to 15 fraction bits, taken from
	// the phase and carried along the chain.
	rot_t chain [NSt+1];
	logic [1:0] quad [NSt+1];
	logic [15:0] su_d [NSt+1];
	always_comb begin
		chain[0].x = CordicGain;
		chain[0].y = '0;
		chain[0].z = {4'b0000, phase[DivBits-3:0], 8'h00};
		quad[0] = phase[DivBits-1:DivBits-2];
		su_d[0] = 16'((17'(phase[DivBits-1:DivBits-16]) + 17'd1) >> 1);
	end
	for (genvar s = 0; s < NSt; s++) begin : g_cell
		cmvg_cell #(.Stage(s)) u_cell (.clk(clk), .din(chain[s]), .dout_q(chain[s+1]));
		always_ff @(posedge clk) begin
			quad[s+1] <= quad[s];
			su_d[s+1] <= su_d[s];
		end
	end

	logic signed [33:0] c_r, s_r;
	always_comb begin
		unique case (quad[NSt])
			2'd0: begin c_r = chain[NSt].x; s_r = chain[NSt].y; end
			2'd1: begin c_r = -chain[NSt].y; s_r = chain[NSt].x; end
			2'd2: begin c_r = -chain[NSt].x; s_r = -chain[NSt].y; end
			default: begin c_r = chain[NSt].y; s_r = -chain[NSt].x; end
		endcase
	end

	// Command delay line aligned with both angles of the segment being ready.
	logic [1:0] op_d [Lat+1];
	logic [10:0] k_d [Lat+1];
	logic v_d [Lat+1];
	logic bad_d [Lat+1];
	always_comb begin
		op_d[0] = opcode;
		k_d[0] = 11'(segment_index);
		v_d[0] = take && (opcode != OP_NONE);
		bad_d[0] = 11'(segment_index) >= n_eff;
	end
	for (genvar d = 0; d < Lat; d++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[d+1] <= 1'b0;
			else v_d[d+1] <= v_d[d];
		end
		always_ff @(posedge clk) begin
			op_d[d+1] <= op_d[d];
			k_d[d+1] <= k_d[d];
			bad_d[d+1] <= bad_d[d];
		end
	end

	// Product stage for radius scaling.
	logic signed [49:0] pc_s1, ps_s1;
	logic signed [33:0] c_s1, s_s1;
	logic [15:0] su_s1;
	always_ff @(posedge clk) begin
		pc_s1 <= 50'(c_r) * $signed({1'b0, radius_q});
		ps_s1 <= 50'(s_r) * $signed({1'b0, radius_q});
		c_s1 <= c_r;
		s_s1 <= s_r;
		su_s1 <= su_d[NSt];
	end

	function automatic logic signed [15:0] f_pos(input logic signed [49:0] p);
		logic signed [49:0] t;
		begin
			t = (p + 50'sd536870912) >>> 30;
			if (t > 50'sd32767) return 16'sd32767;
			if (t < -50'sd32768) return -16'sd32768;
			return t[15:0];
		end
	endfunction
	function automatic logic signed [15:0] f_norm(input logic signed [33:0] c);
		logic signed [33:0] t;
		begin
			t = (c + 34'sd32768) >>> 16;
			if (t > 34'sd16384) return 16'sd16384;
			if (t < -34'sd16384) return -16'sd16384;
			return t[15:0];
		end
	endfunction
	function automatic logic [15:0] f_tex(input logic signed [33:0] c);
		logic signed [33:0] t;
		begin
			t = (c + 34'sd1073774592) >>> 16;
			if (t > 34'sd32768) return 16'd32768;
			if (t < 34'sd0) return 16'd0;
			return t[15:0];
		end
	endfunction

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] nz;
		logic [15:0] tu;
		logic [15:0] tv;
		logic [15:0] su;
	} ang_t;

	ang_t a_s2, a0_q;
	always_ff @(posedge clk) begin
		a_s2.px <= f_pos(pc_s1);
		a_s2.pz <= f_pos(ps_s1);
		a_s2.nx <= f_norm(c_s1);
		a_s2.nz <= f_norm(s_s1);
		a_s2.tu <= f_tex(c_s1);
		a_s2.tv <= f_tex(s_s1);
		a_s2.su <= su_s1;
		a0_q <= a_s2;
	end

	// When go is high, a0_q holds angle k and a_s2 holds angle k + 1.
	logic [1:0] op_l;
	logic [10:0] k_l;
	logic bad_l;
	logic go;
	always_comb begin
		go = v_d[Lat];
		op_l = op_d[Lat];
		k_l = k_d[Lat];
		bad_l = bad_d[Lat];
	end

	logic [2:0] cnt_q;
	logic act_q;
	logic [1:0] op_q;
	logic bad_q;
	logic [10:0] k_q;
	ang_t a1_q, e0_q;
	logic [10:0] nl_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			act_q <= 1'b1;
			cnt_q <= 3'd1;
		end else if (act_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (bad_q || (cnt_q == 3'd3 && op_q != OP_SIDE) || cnt_q == 3'd6) act_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			op_q <= op_l;
			bad_q <= bad_l;
			k_q <= k_l;
			nl_q <= n_eff;
			e0_q <= a0_q;
			a1_q <= a_s2;
		end
	end

	// The last segment ends at the full turn, where side u is one.
	logic wrap;
	assign wrap = (k_q + 11'd1) == nl_q;

	ang_t sel;
	logic [15:0] hv;
	always_comb begin
		hv = {1'b0, height_q[15:1]};
		sel = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		norm_x = '0; norm_y = '0; norm_z = '0;
		tex_u = '0; tex_v = '0;
		last = 1'b0; bad_index = 1'b0;
		out_valid = act_q;
		if (bad_q) begin
			last = 1'b1;
			bad_index = 1'b1;
		end else if (op_q == OP_SIDE) begin
			case (cnt_q)
				3'd1, 3'd2, 3'd4: sel = e0_q;
				default: sel = a1_q;
			endcase
			pos_x = sel.px; pos_z = sel.pz; norm_x = sel.nx; norm_z = sel.nz;
			pos_y = (cnt_q == 3'd1 || cnt_q == 3'd4 || cnt_q == 3'd6) ? -hv : hv;
			tex_v = (cnt_q == 3'd1 || cnt_q == 3'd4 || cnt_q == 3'd6) ? 16'd0 : 16'd32768;
			tex_u = sel.su;
			if (!(cnt_q == 3'd1 || cnt_q == 3'd2 || cnt_q == 3'd4) && wrap) begin
				tex_u = 16'd32768;
			end
			last = cnt_q == 3'd6;
		end else begin
			pos_y = (op_q == OP_TOP) ? hv : -hv;
			norm_y = (op_q == OP_TOP) ? 16'sd16384 : -16'sd16384;
			if (cnt_q == 3'd1) begin
				tex_u = 16'd16384; tex_v = 16'd16384;
			end else begin
				sel = ((cnt_q == 3'd2) == (op_q == OP_TOP)) ? a1_q : e0_q;
				pos_x = sel.px; pos_z = sel.pz; tex_u = sel.tu; tex_v = sel.tv;
			end
			last = cnt_q == 3'd3;
		end
	end

	`CMVG_ASSERT_IMP(a_no_take_busy, clk, arst_n, busy_q > 3'd5, 1'b0)
	`CMVG_ASSERT_IMP(a_bad_last, clk, arst_n, out_valid && bad_index, last)
	`CMVG_ASSERT_NEXT(a_take_busy, clk, arst_n, take, busy)
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cylinder mesh vertex generator unit.
`timescale 1ns / 1ps
class vertex_board;
	typedef struct {
		logic [15:0] f [8];
		logic last;
		logic bad;
	} vertex_t;

	vertex_t pending[$];
	int errors;
	int checked;
	logic [14:0] radius;
	logic [15:0] height;
	logic [10:0] count;

	function new();
		errors = 0;
		checked = 0;
		radius = 15'd256;
		height = 16'd512;
		count = 11'd32;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] data);
		if (idx == cmvg_pkg::REG_RADIUS) begin
			radius = data[14:0];
		end else if (idx == cmvg_pkg::REG_HEIGHT) begin
			height = data;
		end else if (idx == cmvg_pkg::REG_COUNT) begin
			count = data[10:0];
		end
	endfunction

	function longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function void rotate(int k, int n, output longint c, output longint s);
		longint phase, x, y, z, dx, dy, t;
		logic [31:0] turn;
		phase = ((longint'(k) << 24) / n) & 64'hFFFFFF;
		turn = phase[23:0] << 8;
		z = turn[29:0];
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			t = cmvg_pkg::atan_turn(i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		case (turn[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function longint to_pos(longint t);
		return clamp(shr_floor(t * longint'(radius) + (64'sd1 << 29), 30), -32768, 32767);
	endfunction

	function longint to_tex(longint t);
		return clamp(shr_floor(t + (64'sd1 << 30) + 32768, 16), 0, 32768);
	endfunction

	function void push(longint px, longint py, longint pz, longint nx, longint ny,
			longint nz, longint u, longint v, logic lst);
		vertex_t e;
		e.f[0] = px[15:0]; e.f[1] = py[15:0]; e.f[2] = pz[15:0];
		e.f[3] = nx[15:0]; e.f[4] = ny[15:0]; e.f[5] = nz[15:0];
		e.f[6] = u[15:0]; e.f[7] = v[15:0];
		e.last = lst;
		e.bad = 1'b0;
		pending.push_back(e);
	endfunction

	function void note_command(logic [1:0] op, logic [9:0] k);
		int n;
		longint half, c0, s0, c1, s1, u0, u1, y, ny;
		longint ax0, az0, ax1, az1, nx0, nz0, nx1, nz1;
		vertex_t e;
		n = count > 1024 ? 1024 : count;
		half = height >> 1;
		if (op == cmvg_pkg::OP_NONE) begin
			return;
		end
		if (k >= n) begin
			for (int i = 0; i < 8; i++) e.f[i] = '0;
			e.last = 1'b1;
			e.bad = 1'b1;
			pending.push_back(e);
			return;
		end
		rotate(k, n, c0, s0);
		rotate(k + 1, n, c1, s1);
		ax0 = to_pos(c0); az0 = to_pos(s0); ax1 = to_pos(c1); az1 = to_pos(s1);
		if (op == cmvg_pkg::OP_SIDE) begin
			u0 = ((longint'(k) << 15) + n / 2) / n;
			u1 = ((longint'(k + 1) << 15) + n / 2) / n;
			nx0 = clamp(shr_floor(c0 + 32768, 16), -16384, 16384);
			nz0 = clamp(shr_floor(s0 + 32768, 16), -16384, 16384);
			nx1 = clamp(shr_floor(c1 + 32768, 16), -16384, 16384);
			nz1 = clamp(shr_floor(s1 + 32768, 16), -16384, 16384);
			push(ax0, -half, az0, nx0, 0, nz0, u0, 0, 0);
			push(ax0, half, az0, nx0, 0, nz0, u0, 32768, 0);
			push(ax1, half, az1, nx1, 0, nz1, u1, 32768, 0);
			push(ax0, -half, az0, nx0, 0, nz0, u0, 0, 0);
			push(ax1, half, az1, nx1, 0, nz1, u1, 32768, 0);
			push(ax1, -half, az1, nx1, 0, nz1, u1, 0, 1);
		end else begin
			y = op == cmvg_pkg::OP_TOP ? half : -half;
			ny = op == cmvg_pkg::OP_TOP ? 16384 : -16384;
			push(0, y, 0, 0, ny, 0, 16384, 16384, 0);
			if (op == cmvg_pkg::OP_TOP) begin
				push(ax1, y, az1, 0, ny, 0, to_tex(c1), to_tex(s1), 0);
				push(ax0, y, az0, 0, ny, 0, to_tex(c0), to_tex(s0), 1);
			end else begin
				push(ax0, y, az0, 0, ny, 0, to_tex(c0), to_tex(s0), 0);
				push(ax1, y, az1, 0, ny, 0, to_tex(c1), to_tex(s1), 1);
			end
		end
	endfunction

	task report(string what, logic [15:0] got, logic [15:0] want);
		$display("vertex %0d: %s got %h expected %h", checked, what, got, want);
		errors++;
	endtask

	task check_vertex(logic [15:0] f [8], logic lst, logic bad);
		vertex_t e;
		string names [8] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z",
			"tex_u", "tex_v"};
		if (pending.size() == 0) begin
			$display("vertex %0d: result with nothing expected", checked);
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int i = 0; i < 8; i++) begin
			if (f[i] !== e.f[i]) report(names[i], f[i], e.f[i]);
		end
		if (lst !== e.last) report("last", 16'(lst), 16'(e.last));
		if (bad !== e.bad) report("bad_index", 16'(bad), 16'(e.bad));
		checked++;
	endtask
endclass

module testbench;
	import cmvg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = '0;
	logic [9:0] segment_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic out_valid;
	logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
	logic [15:0] tex_u, tex_v;
	logic last, bad_index;

	vertex_board board = new();
	int commands = 0;
	int cfg_writes = 0;
	bit calm = 1'b0;

	cylinder_mesh_vertex_generator_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			board.check_vertex('{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v},
				last, bad_index);
		end
	end

	task wait_drained();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task send(logic [1:0] op, logic [9:0] k);
		if (!calm && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		segment_index <= k;
		do @(posedge clk); while (busy);
		board.note_command(op, k);
		commands++;
	endtask

	task random_phase(int items);
		int n;
		n = board.count > 1024 ? 1024 : board.count;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 9) == 0 || n == 0) begin
				send(2'($urandom_range(0, 3)), 10'($urandom));
			end else begin
				send(2'($urandom_range(0, 2)), 10'($urandom_range(0, n - 1)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(OP_SIDE, 0);
		send(OP_TOP, 0);
		send(OP_BOTTOM, 0);
		send(OP_SIDE, 31);
		send(OP_TOP, 31);
		send(OP_BOTTOM, 31);
		send(OP_SIDE, 32);
		send(OP_NONE, 5);
		send(OP_TOP, 10'h3FF);
		send(OP_SIDE, 8);
		write_reg(REG_RADIUS, 16'h7FFF);
		write_reg(REG_HEIGHT, 16'hFFFF);
		write_reg(REG_COUNT, 16'd1);
		send(OP_SIDE, 0);
		send(OP_TOP, 0);
		send(OP_BOTTOM, 1);
		write_reg(REG_RADIUS, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		write_reg(REG_COUNT, 16'd0);
		send(OP_SIDE, 0);
		send(OP_BOTTOM, 0);
		write_reg(REG_COUNT, 16'h07FF);
		send(OP_SIDE, 10'h3FF);
		send(OP_TOP, 10'h2AA);
		send(OP_BOTTOM, 10'h155);
		write_reg(REG_RADIUS, 16'hFFFF);
		write_reg(REG_COUNT, 16'd1024);
		random_phase(100);
		write_reg(REG_RADIUS, 16'($urandom));
		write_reg(REG_HEIGHT, 16'($urandom));
		write_reg(REG_COUNT, 16'($urandom_range(1, 16)));
		random_phase(100);
		write_reg(REG_COUNT, 16'($urandom_range(3, 200)));
		write_reg(REG_RADIUS, 16'd256);
		random_phase(100);
		write_reg(REG_COUNT, 16'd3);
		write_reg(REG_HEIGHT, 16'd1);
		random_phase(60);
		write_reg(REG_COUNT, 16'($urandom_range(1, 2047)));
		calm = 1'b1;
		random_phase(70);
		wait_drained();
		$display("Sent %0d commands and %0d register writes; checked %0d vertices.",
			commands, cfg_writes, board.checked);
		if (board.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/cmvg_pkg.sv
src/cmvg_cell.sv
src/cmvg_angle.sv
src/cylinder_mesh_vertex_generator_unit.sv
tb/testbench.sv
